// ----- hdl/svf_pkg.sv -----
package svf_pkg;

   // Result word width for every filter output and state
   localparam int OUT_BITS = 32;

   // Coefficient register reset values (freq Q1.16, damp Q2.16 encoding)
   localparam int FREQ_RESET = 2573;
   localparam int DAMP_RESET = 92682;

   // Register map: word index of each CSR
   typedef enum logic [0:0] {
      CSR_FREQ = 1'b0,
      CSR_DAMP = 1'b1
   } csr_index_type;

endpackage

// ----- hdl/state_variable_filter_multimode_top.sv -----
// Channel | Dir | Handshake              | Payload
// req     | in  | req_tvalid/req_tready  | tdata: sample; tuser: clear
// rsp     | out | rsp_tvalid/rsp_tready  | tdata: highpass, bandpass, lowpass (LSB first)
// csr     | in  | psel/penable/pready    | freq_coef @0x0, damp_coef @0x4
//
// A new sample is accepted only after the previous one leaves the sequencer: three
// products run one after another through the single shared multiplier, each
// followed by a round, add and saturate step, and the chain is fully dependent.
// Synchronous active-high reset clears the sequencer, both filter states and
// the coefficient registers (to their default values).
// The result sits in an output register; a new sample is taken while it waits.
// If the previous result is still not taken, the final step holds until it is.
module state_variable_filter_multimode_top #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // input sample channel
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,  // [SAMPLE_BITS-1:0] sample
   input  logic                                    req_tuser,  // [0] clear
   // result channel
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [3 * svf_pkg::OUT_BITS - 1:0]      rsp_tdata,  // highpass, bandpass, lowpass from the LSB up
   // configuration port
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [2:0]                              csr_paddr,
   input  logic [31:0]                             csr_pwdata,
   output logic [31:0]                             csr_prdata,
   output logic                                    csr_pready
);
   import svf_pkg::*;

   localparam int FREQ_BITS = COEF_FRAC_BITS + 1;
   localparam int DAMP_BITS = COEF_FRAC_BITS + 2;
   localparam int COEF_W    = DAMP_BITS + 1;            // signed multiplier coef operand
   localparam int PROD_W    = OUT_BITS + COEF_W;        // full product width
   localparam int RND_W     = PROD_W - COEF_FRAC_BITS;  // scaled product width
   localparam int SUM_W     = RND_W + 2;                // three-operand sum width
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [OUT_BITS-1:0] SAT_MAX = {1'b0, {(OUT_BITS - 1){1'b1}}};
   localparam logic signed [OUT_BITS-1:0] SAT_MIN = {1'b1, {(OUT_BITS - 1){1'b0}}};

   typedef enum logic [2:0] {
      S_IDLE,
      S_DAMP,   // damp * band
      S_HP,     // highpass sum
      S_FHP,    // freq * hp
      S_BP,     // bandpass sum
      S_FBP,    // freq * bp
      S_LP      // lowpass sum, result out
   } state_type;

   state_type                    state_ff;
   logic [FREQ_BITS-1:0]         freq_ff;
   logic [DAMP_BITS-1:0]         damp_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [OUT_BITS-1:0]   band_ff;
   logic signed [OUT_BITS-1:0]   low_ff;
   logic signed [OUT_BITS-1:0]   hp_ff;
   logic signed [PROD_W-1:0]     prod_ff;
   logic                         rsp_tvalid_ff;
   logic [3*OUT_BITS-1:0]        rsp_tdata_ff;

   logic signed [OUT_BITS-1:0]   mul_data;
   logic signed [COEF_W-1:0]     mul_coef;
   logic signed [PROD_W-1:0]     prod_in;
   logic signed [PROD_W-1:0]     prod_rnd;
   logic signed [RND_W-1:0]      scaled;
   logic signed [SUM_W-1:0]      opnd_a;
   logic signed [SUM_W-1:0]      opnd_b;
   logic signed [SUM_W-1:0]      opnd_c;
   logic signed [SUM_W-1:0]      acc_in;
   logic signed [OUT_BITS-1:0]   sat_in;
   logic                         req_fire;
   logic                         out_free;
   logic                         csr_write;

   // clamp a wide sum to the signed 32-bit range
   function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [SUM_W-1:0] v);
      logic signed [OUT_BITS-1:0] r;
      if (v[SUM_W-1:OUT_BITS-1] != {(SUM_W - OUT_BITS + 1){v[SUM_W-1]}}) begin
         r = v[SUM_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
         r = v[OUT_BITS-1:0];
      end
      return r;
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= FREQ_BITS'(FREQ_RESET);
         damp_ff <= DAMP_BITS'(DAMP_RESET);
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_paddr[2]))
            CSR_FREQ: freq_ff <= csr_pwdata[FREQ_BITS-1:0];
            CSR_DAMP: damp_ff <= csr_pwdata[DAMP_BITS-1:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index_type'(csr_paddr[2]))
         CSR_FREQ: csr_prdata = 32'(freq_ff);
         CSR_DAMP: csr_prdata = 32'(damp_ff);
         default:  csr_prdata = '0;
      endcase
   end

   // shared multiplier: coefficient times a state or hp value
   always_comb begin
      mul_data = (state_ff == S_FHP) ? hp_ff : band_ff;
      mul_coef = (state_ff == S_DAMP) ? $signed(COEF_W'(damp_ff)) : $signed(COEF_W'(freq_ff));
      prod_in  = PROD_W'(mul_data) * PROD_W'(mul_coef);
   end

   // round half up, scale down, then the shared three-input adder
   always_comb begin
      prod_rnd = prod_ff + ROUND_HALF;
      scaled   = prod_rnd[PROD_W-1:COEF_FRAC_BITS];
      case (state_ff)
         S_HP: begin
            opnd_a = SUM_W'(sample_ff);
            opnd_b = -SUM_W'(low_ff);
            opnd_c = -SUM_W'(scaled);
         end
         S_BP: begin
            opnd_a = SUM_W'(scaled);
            opnd_b = SUM_W'(band_ff);
            opnd_c = '0;
         end
         default: begin
            opnd_a = SUM_W'(scaled);
            opnd_b = SUM_W'(low_ff);
            opnd_c = '0;
         end
      endcase
      acc_in = opnd_a + opnd_b + opnd_c;
      sat_in = sat_out(acc_in);
   end

   // sequencer, filter state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         band_ff       <= '0;
         low_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // taken result drops, unless the lowpass step refills it this cycle
         if (rsp_tvalid_ff && rsp_tready && state_ff != S_LP) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  sample_ff <= req_tdata[SAMPLE_BITS-1:0];
                  if (req_tuser) begin
                     band_ff <= '0;
                     low_ff  <= '0;
                  end
                  state_ff <= S_DAMP;
               end
            end
            S_DAMP: begin
               prod_ff  <= prod_in;
               state_ff <= S_HP;
            end
            S_HP: begin
               hp_ff    <= sat_in;
               state_ff <= S_FHP;
            end
            S_FHP: begin
               prod_ff  <= prod_in;
               state_ff <= S_BP;
            end
            S_BP: begin
               band_ff  <= sat_in;
               state_ff <= S_FBP;
            end
            S_FBP: begin
               prod_ff  <= prod_in;
               state_ff <= S_LP;
            end
            S_LP: begin
               if (out_free) begin
                  low_ff        <= sat_in;
                  rsp_tdata_ff  <= {sat_in, band_ff, hp_ff};
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // a result appears only from the lowpass step
   a_rsp_from_lp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_LP))
      else $error("result raised outside the lowpass step");

   // a result is withdrawn only after it was taken
   a_rsp_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_tvalid_ff) |-> $past(rsp_tready))
      else $error("result dropped before it was taken");

   // an accepted sample starts the damping product
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_DAMP))
      else $error("sequencer did not start after acceptance");

   // clear flag zeroes both filter states
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser) |=> (band_ff == '0 && low_ff == '0))
      else $error("clear did not zero the filter states");

endmodule
